/* rtl/rsi_pkg.sv */
// Shared types, constants and the microcode table of the RSI smoothing block.
package rsi_pkg;

   localparam int PRICE_WIDTH_DEF = 32;
   localparam int PERIOD_W        = 8;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
   localparam int COUNT_W         = 9;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd256;
   localparam int FRAC_SHIFT      = 16;
   localparam int RSI_W           = 23;
   localparam logic [RSI_W-1:0] RSI_FULL = 23'd6553600;
   localparam int NORM_BIT        = 39;
   localparam int SUM_W           = 40;
   localparam int PROD_W          = 62;
   localparam int PC_W            = 5;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_ADD,
      OP_START_AVG,
      OP_START_WILDER,
      OP_WRITE_AVG,
      OP_BOOK,
      OP_NORM,
      OP_MUL,
      OP_START_RSI,
      OP_EMIT_RSI,
      OP_EMIT_FULL,
      OP_EMIT_INSUF
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_NO_UPD,
      C_SMOOTH,
      C_NOT_CONV,
      C_DIV_BUSY,
      C_NOT_LAST,
      C_INSUF,
      C_NORM,
      C_LOSS_ZERO
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            hold_out;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic no_upd;
      logic smooth;
      logic not_conv;
      logic div_busy;
      logic not_last;
      logic insuf;
      logic norm_needed;
      logic loss_zero;
      logic out_busy;
   } status_type;

   localparam logic [PC_W-1:0] ST_ACCEPT     = 5'd0;
   localparam logic [PC_W-1:0] ST_CHECK      = 5'd1;
   localparam logic [PC_W-1:0] ST_PHASE      = 5'd2;
   localparam logic [PC_W-1:0] ST_ADD        = 5'd3;
   localparam logic [PC_W-1:0] ST_AVG        = 5'd4;
   localparam logic [PC_W-1:0] ST_WILDER     = 5'd5;
   localparam logic [PC_W-1:0] ST_DIV_WAIT   = 5'd6;
   localparam logic [PC_W-1:0] ST_WRITE      = 5'd7;
   localparam logic [PC_W-1:0] ST_BOOK       = 5'd8;
   localparam logic [PC_W-1:0] ST_END        = 5'd9;
   localparam logic [PC_W-1:0] ST_NORM       = 5'd10;
   localparam logic [PC_W-1:0] ST_MUL        = 5'd11;
   localparam logic [PC_W-1:0] ST_RSI        = 5'd12;
   localparam logic [PC_W-1:0] ST_RSI_WAIT   = 5'd13;
   localparam logic [PC_W-1:0] ST_EMIT_RSI   = 5'd14;
   localparam logic [PC_W-1:0] ST_EMIT_FULL  = 5'd15;
   localparam logic [PC_W-1:0] ST_EMIT_INSUF = 5'd16;

   // Control word per step: jump to target when the condition holds, else step on.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_ACCEPT, hold_out: 1'b0};
      case (pc)
         ST_ACCEPT:     w = '{op: OP_ACCEPT,       cond: C_NO_REQ,    target: ST_ACCEPT,
                              hold_out: 1'b0};
         ST_CHECK:      w = '{op: OP_NOP,          cond: C_NO_UPD,    target: ST_BOOK,
                              hold_out: 1'b0};
         ST_PHASE:      w = '{op: OP_NOP,          cond: C_SMOOTH,    target: ST_WILDER,
                              hold_out: 1'b0};
         ST_ADD:        w = '{op: OP_ADD,          cond: C_NOT_CONV,  target: ST_BOOK,
                              hold_out: 1'b0};
         ST_AVG:        w = '{op: OP_START_AVG,    cond: C_ALWAYS,    target: ST_DIV_WAIT,
                              hold_out: 1'b0};
         ST_WILDER:     w = '{op: OP_START_WILDER, cond: C_NEVER,     target: ST_ACCEPT,
                              hold_out: 1'b0};
         ST_DIV_WAIT:   w = '{op: OP_NOP,          cond: C_DIV_BUSY,  target: ST_DIV_WAIT,
                              hold_out: 1'b0};
         ST_WRITE:      w = '{op: OP_WRITE_AVG,    cond: C_NEVER,     target: ST_ACCEPT,
                              hold_out: 1'b0};
         ST_BOOK:       w = '{op: OP_BOOK,         cond: C_NOT_LAST,  target: ST_ACCEPT,
                              hold_out: 1'b0};
         ST_END:        w = '{op: OP_NOP,          cond: C_INSUF,     target: ST_EMIT_INSUF,
                              hold_out: 1'b0};
         ST_NORM:       w = '{op: OP_NORM,         cond: C_NORM,      target: ST_NORM,
                              hold_out: 1'b0};
         ST_MUL:        w = '{op: OP_MUL,          cond: C_LOSS_ZERO, target: ST_EMIT_FULL,
                              hold_out: 1'b0};
         ST_RSI:        w = '{op: OP_START_RSI,    cond: C_NEVER,     target: ST_ACCEPT,
                              hold_out: 1'b0};
         ST_RSI_WAIT:   w = '{op: OP_NOP,          cond: C_DIV_BUSY,  target: ST_RSI_WAIT,
                              hold_out: 1'b0};
         ST_EMIT_RSI:   w = '{op: OP_EMIT_RSI,     cond: C_ALWAYS,    target: ST_ACCEPT,
                              hold_out: 1'b1};
         ST_EMIT_FULL:  w = '{op: OP_EMIT_FULL,    cond: C_ALWAYS,    target: ST_ACCEPT,
                              hold_out: 1'b1};
         ST_EMIT_INSUF: w = '{op: OP_EMIT_INSUF,   cond: C_ALWAYS,    target: ST_ACCEPT,
                              hold_out: 1'b1};
         default:       w = '{op: OP_NOP,          cond: C_ALWAYS,    target: ST_ACCEPT,
                              hold_out: 1'b0};
      endcase
      return w;
   endfunction

endpackage

/* rtl/rsi_wilder_smoothing.sv */
// Top level of the RSI block with Wilder smoothing.
//
// Request channel (req_valid/req_ready): one price per request, unsigned Q16.16, with
// req_last on the final price of a series. Response channel (rsp_valid/rsp_ready): one
// response per series, rsp_rsi as Q7.16 (0 to 100) and rsp_status set when the series
// held no more than period prices or the period is 0. csr_write_en/csr_write_data set
// the period; write it between series only.
// Timing: a microcoded sequencer runs each request through a plain datapath. A price in
// the initial averaging window steps through accept, check, phase, add and book. The
// price that closes the window and every later one run two divider lanes in parallel
// (gain and loss), one quotient bit per cycle over PRICE_WIDTH+16 bits.
// A last price adds up to PRICE_WIDTH-23 normalize shifts, a multiply and, unless the
// loss average is zero, one more divider pass for the ratio; a short series goes
// straight to its response.
// The response sits in an output register; the sequencer moves on to the next request
// while it waits, and stalls only if a second response is ready before the first leaves.
// Reset: synchronous; clears the series state and the response valid flag and loads the
// period with 14.
module rsi_wilder_smoothing #(
   parameter int PRICE_WIDTH = rsi_pkg::PRICE_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [PRICE_WIDTH-1:0]       req_price,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rsi_pkg::RSI_W-1:0]    rsp_rsi,
   output logic                         rsp_status,
   input  logic                         csr_write_en,
   input  logic [rsi_pkg::PERIOD_W-1:0] csr_write_data
);

   rsi_pkg::op_type     op;
   rsi_pkg::status_type status;

   // Take a request only on the accept step of the program.
   assign req_ready = (op == rsi_pkg::OP_ACCEPT);

   rsi_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   rsi_dp #(
      .PRICE_WIDTH (PRICE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .status         (status),
      .req_valid      (req_valid),
      .req_price      (req_price),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rsi        (rsp_rsi),
      .rsp_status     (rsp_status),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

endmodule

/* rtl/rsi_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module rsi_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 40,
   parameter int QUO_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [QUO_W-1:0] quo
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // Caller guarantees numer >> QUO_W is below denom, so only QUO_W steps are needed.
   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = DEN_W'(numer >> QUO_W);
         quo_in  = numer[QUO_W-1:0];
         den_in  = denom;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

/* rtl/rsi_seq.sv */
// Microcode sequencer: step counter, control table lookup and conditional jumps.
module rsi_seq (
   input  logic                clock,
   input  logic                reset,
   input  rsi_pkg::status_type status,
   output rsi_pkg::op_type     op
);

   logic [rsi_pkg::PC_W-1:0] pc_ff, pc_in;
   rsi_pkg::ucode_type       word;
   logic                     taken;

   always_comb begin
      word = rsi_pkg::ucode_rom(pc_ff);
      unique case (word.cond)
         rsi_pkg::C_NEVER:     taken = 1'b0;
         rsi_pkg::C_ALWAYS:    taken = 1'b1;
         rsi_pkg::C_NO_REQ:    taken = !status.req_valid;
         rsi_pkg::C_NO_UPD:    taken = status.no_upd;
         rsi_pkg::C_SMOOTH:    taken = status.smooth;
         rsi_pkg::C_NOT_CONV:  taken = status.not_conv;
         rsi_pkg::C_DIV_BUSY:  taken = status.div_busy;
         rsi_pkg::C_NOT_LAST:  taken = status.not_last;
         rsi_pkg::C_INSUF:     taken = status.insuf;
         rsi_pkg::C_NORM:      taken = status.norm_needed;
         rsi_pkg::C_LOSS_ZERO: taken = status.loss_zero;
         default:              taken = 1'b0;
      endcase
      // Hold on an emit step until the result register can take a new result.
      if (word.hold_out && status.out_busy) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + rsi_pkg::PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= rsi_pkg::ST_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = word.op;

endmodule

/* rtl/rsi_dp.sv */
// Datapath: series state, averages, two divider lanes and the result register.
module rsi_dp #(
   parameter int PRICE_WIDTH = rsi_pkg::PRICE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rsi_pkg::op_type               op,
   output rsi_pkg::status_type           status,
   input  logic                          req_valid,
   input  logic [PRICE_WIDTH-1:0]        req_price,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rsi_pkg::RSI_W-1:0]     rsp_rsi,
   output logic                          rsp_status,
   input  logic                          csr_write_en,
   input  logic [rsi_pkg::PERIOD_W-1:0]  csr_write_data
);

   localparam int AVG_W = PRICE_WIDTH + rsi_pkg::FRAC_SHIFT;
   localparam int NUM_W = (AVG_W + rsi_pkg::FRAC_SHIFT > rsi_pkg::PROD_W) ?
                          AVG_W + rsi_pkg::FRAC_SHIFT : rsi_pkg::PROD_W;
   localparam int X_W   = (AVG_W > rsi_pkg::SUM_W) ? AVG_W : rsi_pkg::SUM_W;
   localparam int DEN_W = rsi_pkg::SUM_W;

   logic [rsi_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [PRICE_WIDTH-1:0]       prev_ff, prev_in;
   logic [PRICE_WIDTH-1:0]       cur_ff, cur_in;
   logic [PRICE_WIDTH-1:0]       gain_ff, gain_in;
   logic [PRICE_WIDTH-1:0]       loss_ff, loss_in;
   logic                         last_ff, last_in;
   logic [rsi_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [AVG_W-1:0]             avg_g_ff, avg_g_in;
   logic [AVG_W-1:0]             avg_l_ff, avg_l_in;
   logic                         up_g_ff, up_g_in;
   logic                         up_l_ff, up_l_in;
   logic                         wilder_ff, wilder_in;
   logic [rsi_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [rsi_pkg::SUM_W-1:0]    dsum_ff, dsum_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rsi_pkg::RSI_W-1:0]    rsp_rsi_ff, rsp_rsi_in;
   logic                         rsp_status_ff, rsp_status_in;

   logic [rsi_pkg::COUNT_W-1:0]  period_ext;
   logic [AVG_W-1:0]             x_g, x_l;
   logic [X_W-1:0]               g_ext, l_ext;
   logic [rsi_pkg::NORM_BIT-1:0] g_low, l_low;
   logic                         out_busy;
   logic                         start_g, start_l;
   logic [NUM_W-1:0]             num_g, num_l;
   logic [DEN_W-1:0]             den;
   logic                         busy_g, busy_l;
   logic [AVG_W-1:0]             quo_g, quo_l;

   assign period_ext = rsi_pkg::COUNT_W'(period_ff);
   assign x_g        = {gain_ff, rsi_pkg::FRAC_SHIFT'(0)};
   assign x_l        = {loss_ff, rsi_pkg::FRAC_SHIFT'(0)};
   assign g_ext      = X_W'(avg_g_ff);
   assign l_ext      = X_W'(avg_l_ff);
   assign g_low      = g_ext[rsi_pkg::NORM_BIT-1:0];
   assign l_low      = l_ext[rsi_pkg::NORM_BIT-1:0];
   assign out_busy   = rsp_valid_ff && !rsp_ready;

   always_comb begin
      status.req_valid   = req_valid;
      status.no_upd      = (count_ff == '0) || (period_ff == '0);
      status.smooth      = count_ff > period_ext;
      status.not_conv    = count_ff != period_ext;
      status.div_busy    = busy_g || busy_l;
      status.not_last    = !last_ff;
      status.insuf       = (period_ff == '0) || (count_ff <= period_ext);
      status.norm_needed = (|g_ext[X_W-1:rsi_pkg::NORM_BIT]) ||
                           (|l_ext[X_W-1:rsi_pkg::NORM_BIT]);
      status.loss_zero   = avg_l_ff == '0;
      status.out_busy    = out_busy;
   end

   // Divider operands: sum to average, Wilder step (ceiling on the way down), RSI ratio.
   always_comb begin
      start_g = 1'b0;
      start_l = 1'b0;
      num_g   = '0;
      num_l   = '0;
      den     = DEN_W'(period_ff);
      case (op)
         rsi_pkg::OP_START_AVG: begin
            start_g = 1'b1;
            start_l = 1'b1;
            num_g   = NUM_W'({avg_g_ff, rsi_pkg::FRAC_SHIFT'(0)});
            num_l   = NUM_W'({avg_l_ff, rsi_pkg::FRAC_SHIFT'(0)});
         end
         rsi_pkg::OP_START_WILDER: begin
            start_g = 1'b1;
            start_l = 1'b1;
            if (x_g >= avg_g_ff) begin
               num_g = NUM_W'(x_g - avg_g_ff);
            end else begin
               num_g = NUM_W'((AVG_W+1)'(avg_g_ff - x_g) +
                              (AVG_W+1)'(period_ff - rsi_pkg::PERIOD_W'(1)));
            end
            if (x_l >= avg_l_ff) begin
               num_l = NUM_W'(x_l - avg_l_ff);
            end else begin
               num_l = NUM_W'((AVG_W+1)'(avg_l_ff - x_l) +
                              (AVG_W+1)'(period_ff - rsi_pkg::PERIOD_W'(1)));
            end
         end
         rsi_pkg::OP_START_RSI: begin
            start_g = 1'b1;
            num_g   = NUM_W'(prod_ff);
            den     = dsum_ff;
         end
         default: begin
            start_g = 1'b0;
         end
      endcase
   end

   always_comb begin
      period_in     = csr_write_en ? csr_write_data : period_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      gain_in       = gain_ff;
      loss_in       = loss_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      avg_g_in      = avg_g_ff;
      avg_l_in      = avg_l_ff;
      up_g_in       = up_g_ff;
      up_l_in       = up_l_ff;
      wilder_in     = wilder_ff;
      prod_in       = prod_ff;
      dsum_in       = dsum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_rsi_in    = rsp_rsi_ff;
      rsp_status_in = rsp_status_ff;
      case (op)
         rsi_pkg::OP_ACCEPT: begin
            if (req_valid) begin
               cur_in  = req_price;
               last_in = req_last;
               gain_in = (req_price > prev_ff) ? req_price - prev_ff : '0;
               loss_in = (req_price < prev_ff) ? prev_ff - req_price : '0;
            end
         end
         rsi_pkg::OP_ADD: begin
            avg_g_in = avg_g_ff + AVG_W'(gain_ff);
            avg_l_in = avg_l_ff + AVG_W'(loss_ff);
         end
         rsi_pkg::OP_START_AVG: begin
            wilder_in = 1'b0;
         end
         rsi_pkg::OP_START_WILDER: begin
            wilder_in = 1'b1;
            up_g_in   = x_g >= avg_g_ff;
            up_l_in   = x_l >= avg_l_ff;
         end
         rsi_pkg::OP_WRITE_AVG: begin
            if (!wilder_ff) begin
               avg_g_in = quo_g;
               avg_l_in = quo_l;
            end else begin
               avg_g_in = up_g_ff ? avg_g_ff + quo_g : avg_g_ff - quo_g;
               avg_l_in = up_l_ff ? avg_l_ff + quo_l : avg_l_ff - quo_l;
            end
         end
         rsi_pkg::OP_BOOK: begin
            prev_in = cur_ff;
            if (count_ff < rsi_pkg::COUNT_MAX) begin
               count_in = count_ff + rsi_pkg::COUNT_W'(1);
            end
         end
         rsi_pkg::OP_NORM: begin
            if (status.norm_needed) begin
               avg_g_in = avg_g_ff >> 1;
               avg_l_in = avg_l_ff >> 1;
            end
         end
         rsi_pkg::OP_MUL: begin
            prod_in = rsi_pkg::PROD_W'(rsi_pkg::RSI_FULL) * rsi_pkg::PROD_W'(g_low);
            dsum_in = rsi_pkg::SUM_W'(g_low) + rsi_pkg::SUM_W'(l_low);
         end
         rsi_pkg::OP_EMIT_RSI, rsi_pkg::OP_EMIT_FULL, rsi_pkg::OP_EMIT_INSUF: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               if (op == rsi_pkg::OP_EMIT_RSI) begin
                  rsp_rsi_in    = (quo_g > AVG_W'(rsi_pkg::RSI_FULL)) ?
                                  rsi_pkg::RSI_FULL : quo_g[rsi_pkg::RSI_W-1:0];
                  rsp_status_in = 1'b0;
               end else if (op == rsi_pkg::OP_EMIT_FULL) begin
                  rsp_rsi_in    = rsi_pkg::RSI_FULL;
                  rsp_status_in = 1'b0;
               end else begin
                  rsp_rsi_in    = '0;
                  rsp_status_in = 1'b1;
               end
               // Clear the series for the next one.
               prev_in  = '0;
               count_in = '0;
               avg_g_in = '0;
               avg_l_in = '0;
            end
         end
         default: begin
            rsp_rsi_in = rsp_rsi_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= rsi_pkg::PERIOD_RESET;
         prev_ff      <= '0;
         count_ff     <= '0;
         avg_g_ff     <= '0;
         avg_l_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         avg_g_ff     <= avg_g_in;
         avg_l_ff     <= avg_l_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      gain_ff       <= gain_in;
      loss_ff       <= loss_in;
      last_ff       <= last_in;
      up_g_ff       <= up_g_in;
      up_l_ff       <= up_l_in;
      wilder_ff     <= wilder_in;
      prod_ff       <= prod_in;
      dsum_ff       <= dsum_in;
      rsp_rsi_ff    <= rsp_rsi_in;
      rsp_status_ff <= rsp_status_in;
   end

   rsi_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (AVG_W)
   ) u_div_gain (
      .clock (clock),
      .reset (reset),
      .start (start_g),
      .numer (num_g),
      .denom (den),
      .busy  (busy_g),
      .quo   (quo_g)
   );

   rsi_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (AVG_W)
   ) u_div_loss (
      .clock (clock),
      .reset (reset),
      .start (start_l),
      .numer (num_l),
      .denom (den),
      .busy  (busy_l),
      .quo   (quo_l)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rsi    = rsp_rsi_ff;
   assign rsp_status = rsp_status_ff;

endmodule
